>>> rtl/sgdc_pkg.sv
// ----------------------------------------------------------------------------
// sgdc_pkg
// Shared types and constants of the scatter-gather descriptor chain unit:
// request and result layouts, function and status codes, control word bits.
// ----------------------------------------------------------------------------
`default_nettype none

package sgdc_pkg;

  // function codes of a request
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // status codes of a result
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  // descriptor control word bits
  localparam logic [31:0] CTL_END    = 32'h8000_0000;
  localparam logic [31:0] CTL_FORMAT = 32'h4000_0000;
  localparam logic [31:0] CTL_INTR   = 32'h0001_0000;

  // chain limits that do not vary
  localparam logic [22:0] TOTAL_MAX   = 23'h7F_FFFF;
  localparam int unsigned CHUNK_LIMIT = 64;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] segment_addr;
    logic [21:0] segment_length;
    logic        last_segment;
    logic [31:0] current_address;
  } sgdc_req_t;

  typedef struct packed {
    logic [31:0] desc_control;
    logic [31:0] desc_data_addr;
    logic [31:0] desc_branch_addr;
    logic [22:0] residue;
    logic [1:0]  status;
    logic        last_result;
  } sgdc_res_t;

  // one stored chunk
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] len;
  } sgdc_chunk_t;

endpackage

`default_nettype wire

>>> rtl/sgdc_chunk_ram.sv
// ----------------------------------------------------------------------------
// sgdc_chunk_ram
// Chunk store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sgdc_chunk_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AW-1:0]       waddr_i,
  input  wire sgdc_pkg::sgdc_chunk_t wdata_i,
  input  wire logic [AW-1:0]       raddr_i,
  output sgdc_pkg::sgdc_chunk_t    rdata_o
);
  import sgdc_pkg::*;

  sgdc_chunk_t mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/sg_descriptor_chain_with_residue_unit.sv
// ----------------------------------------------------------------------------
// sg_descriptor_chain_with_residue_unit
// Builds a linked scatter-gather descriptor chain from appended segments and
// answers residue queries by walking the stored chunks.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy drops in the
// cycle that shows the last result of that request. Each result appears on res_o
// for exactly one cycle with res_valid_o high and must be taken then, since the
// receiver cannot hold results off. A clear gives no result. An append first
// counts its chunks with the shared split unit (counting stops at 64 chunks) so
// that overflow is known before anything is emitted, then splits the segment
// again, one descriptor per cycle. A query walks the stored chunks one per cycle
// through the single read port of the chunk store. Configuration is to be
// written only while the unit is idle; the unit itself does not enforce this.
`default_nettype none

module sg_descriptor_chain_with_residue_unit #(
  parameter int unsigned MAX_DESCRIPTORS = 128,
  parameter int unsigned MAX_CHUNK_BYTES = 65532
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire sgdc_pkg::sgdc_req_t  req_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [31:0]          cfg_wdata_i,
  output logic                      res_valid_o,
  output sgdc_pkg::sgdc_res_t       res_o
);
  import sgdc_pkg::*;

  localparam int unsigned IW = $clog2(MAX_DESCRIPTORS);
  localparam int unsigned CW = $clog2(MAX_DESCRIPTORS + 1);
  localparam int unsigned SW = CW + 8;
  localparam logic [21:0] MaxChunk = 22'(MAX_CHUNK_BYTES);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_COUNT   = 6'b000010,
    S_CHECK   = 6'b000100,
    S_EMIT    = 6'b001000,
    S_LASTOUT = 6'b010000,
    S_QCMP    = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  sgdc_req_t   req_q, req_d;
  logic [31:0] base_q, base_d;
  logic [21:0] rem_q, rem_d;
  logic [31:0] addr_q, addr_d;
  logic [6:0]  n_q, n_d;
  logic        big_q, big_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [22:0] total_q, total_d;
  logic [22:0] done_q, done_d;
  logic        res_valid_q, res_valid_d;
  sgdc_res_t   res_q, res_d;

  logic        ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  sgdc_chunk_t ram_wdata, ram_rdata;

  // shared split unit
  logic        fin;
  logic [21:0] rem_sub;
  logic [15:0] split_len;

  // query compare
  logic [32:0] chunk_hi;
  logic        hit;
  logic [15:0] offs;
  logic [CW-1:0] idx_nxt;

  // overflow check
  logic [SW-1:0] fill_sum;
  logic [23:0]   total_sum;
  logic          ovf;

  logic accept;

  assign accept = start && !busy;

  assign fin       = (rem_q <= MaxChunk);
  assign rem_sub   = rem_q - MaxChunk;
  assign split_len = fin ? rem_q[15:0] : MaxChunk[15:0];

  assign chunk_hi = {1'b0, ram_rdata.addr} + {17'd0, ram_rdata.len};
  assign hit      = (req_q.current_address >= ram_rdata.addr) &&
                    ({1'b0, req_q.current_address} <= chunk_hi);
  assign offs     = 16'(req_q.current_address - ram_rdata.addr);
  assign idx_nxt  = idx_q + 1'b1;

  assign fill_sum  = SW'(cnt_q) + SW'(n_q);
  assign total_sum = {1'b0, total_q} + {2'b00, req_q.segment_length};
  assign ovf       = big_q || (fill_sum > SW'(MAX_DESCRIPTORS)) ||
                     (total_sum > {1'b0, TOTAL_MAX});

  sgdc_chunk_ram #(
    .DEPTH(MAX_DESCRIPTORS),
    .AW   (IW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    base_d      = base_q;
    rem_d       = rem_q;
    addr_d      = addr_q;
    n_d         = n_q;
    big_d       = big_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    total_d     = total_q;
    done_d      = done_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[IW-1:0];
    ram_wdata   = '{addr: addr_q, len: split_len};
    ram_raddr   = '0;

    if (cfg_we_i) begin
      base_d = cfg_wdata_i;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = req_i;
          rem_d = req_i.segment_length;
          n_d   = '0;
          big_d = 1'b0;
          idx_d = '0;
          done_d = '0;
          case (req_i.func)
            FUNC_CLEAR: begin
              cnt_d   = '0;
              total_d = '0;
            end
            FUNC_APPEND: begin
              if (req_i.segment_length != '0) begin
                state_d = S_COUNT;
              end else if (req_i.last_segment) begin
                if (cnt_q == '0) begin
                  res_valid_d        = 1'b1;
                  res_d.status       = ST_EMPTY;
                  res_d.last_result  = 1'b1;
                end else begin
                  ram_raddr = IW'(cnt_q - 1'b1);
                  state_d   = S_LASTOUT;
                end
              end
            end
            FUNC_QUERY: begin
              if (cnt_q == '0) begin
                res_valid_d       = 1'b1;
                res_d.status      = ST_EMPTY;
                res_d.last_result = 1'b1;
              end else begin
                ram_raddr = '0;
                state_d   = S_QCMP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // count chunks with the split unit, capped at the chunk limit
      S_COUNT: begin
        n_d = n_q + 1'b1;
        if (fin) begin
          state_d = S_CHECK;
        end else begin
          rem_d = rem_sub;
          if (n_q == 7'(CHUNK_LIMIT - 1)) begin
            big_d   = 1'b1;
            state_d = S_CHECK;
          end
        end
      end

      // refuse the segment or rewind for emission
      S_CHECK: begin
        if (ovf) begin
          res_valid_d       = 1'b1;
          res_d.status      = ST_OVERFLOW;
          res_d.last_result = 1'b1;
          state_d           = S_IDLE;
        end else begin
          rem_d   = req_q.segment_length;
          addr_d  = req_q.segment_addr;
          state_d = S_EMIT;
        end
      end

      // one descriptor per cycle, chunk stored at the next slot
      S_EMIT: begin
        ram_we                 = 1'b1;
        res_valid_d            = 1'b1;
        res_d.desc_control     = {16'd0, split_len} | CTL_FORMAT |
                                 ((fin && req_q.last_segment) ? (CTL_END | CTL_INTR) : '0);
        res_d.desc_data_addr   = addr_q;
        res_d.desc_branch_addr = base_q + ((32'(cnt_q) + 32'd1) << 4);
        res_d.status           = ST_OK;
        res_d.last_result      = fin;
        cnt_d   = cnt_q + 1'b1;
        total_d = total_q + {7'd0, split_len};
        addr_d  = addr_q + {16'd0, split_len};
        rem_d   = rem_q - {6'd0, split_len};
        if (fin) begin
          state_d = S_IDLE;
        end
      end

      // re-emit the final stored descriptor with end and interrupt set
      S_LASTOUT: begin
        res_valid_d            = 1'b1;
        res_d.desc_control     = {16'd0, ram_rdata.len} | CTL_FORMAT | CTL_END | CTL_INTR;
        res_d.desc_data_addr   = ram_rdata.addr;
        res_d.desc_branch_addr = base_q + (32'(cnt_q) << 4);
        res_d.status           = ST_OK;
        res_d.last_result      = 1'b1;
        state_d                = S_IDLE;
      end

      // walk stored chunks, next entry prefetched each cycle
      S_QCMP: begin
        ram_raddr = idx_nxt[IW-1:0];
        if (hit) begin
          res_valid_d       = 1'b1;
          res_d.residue     = total_q - done_q - {7'd0, offs};
          res_d.status      = ST_OK;
          res_d.last_result = 1'b1;
          state_d           = S_IDLE;
        end else begin
          done_d = done_q + {7'd0, ram_rdata.len};
          idx_d  = idx_nxt;
          if (idx_nxt == cnt_q) begin
            res_valid_d       = 1'b1;
            res_d.residue     = total_q;
            res_d.status      = ST_OK;
            res_d.last_result = 1'b1;
            state_d           = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      cnt_q       <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
    end
  end

  // working registers and result payload
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rem_q  <= rem_d;
    addr_q <= addr_d;
    n_q    <= n_d;
    big_q  <= big_d;
    idx_q  <= idx_d;
    done_q <= done_d;
    res_q  <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // table never fills past its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_DESCRIPTORS))
    else $error("chunk count past table depth");

  // stores only go to a free slot
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (cnt_q < CW'(MAX_DESCRIPTORS)))
    else $error("chunk write beyond table");

  // busy only rises after a taken request
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy without request");

  // error and empty results are always the final one
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status != ST_OK)) |-> res_o.last_result)
    else $error("error result not final");

  // descriptor and residue results never mix
  a_res_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.residue != '0)) |-> (res_o.desc_control == '0))
    else $error("residue on descriptor result");

  // the total holds in the count, re-emit and query states
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_QCMP) || (state_q == S_LASTOUT) || (state_q == S_COUNT)) |=>
      $stable(total_q))
    else $error("total changed outside emission");

endmodule

`default_nettype wire

>>> bench/sg_descriptor_chain_with_residue_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sg_descriptor_chain_with_residue_unit_test
// Self-checking bench for the scatter-gather descriptor chain unit. A shadow
// copy of the chunk table predicts every descriptor, residue answer and flag
// of each accepted request; a monitor compares the unit's results in order.
// Directed requests hit the table limits, wrap cases and empty chains, then
// random chains of appends and queries run under several table base settings.
// ----------------------------------------------------------------------------
module sg_descriptor_chain_with_residue_unit_test;

  import sgdc_pkg::*;

  localparam int unsigned TABLE_SLOTS = 128;
  localparam int unsigned CHUNK_BYTES = 65532;
  localparam int unsigned RUN_LIMIT   = 400000;
  localparam int unsigned RANDOM_PER_PHASE = 18;

  // function code the unit leaves unused
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    sgdc_req_t req;
    bit        drain;   // hold off until the unit has caught up
  } queued_request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  sgdc_req_t   req_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        res_valid_o;
  sgdc_res_t   res_o;

  queued_request_t requests_pending[$];
  sgdc_res_t       descriptors_due[$];

  // shadow of the chain state
  logic [31:0] shadow_addr[TABLE_SLOTS];
  logic [15:0] shadow_len[TABLE_SLOTS];
  int unsigned shadow_count = 0;
  int unsigned shadow_total = 0;
  logic [31:0] shadow_base = '0;

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned requests_accepted = 0;
  int unsigned descriptors_seen = 0;
  int unsigned residues_seen = 0;
  int unsigned flags_seen = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic        raise_start;

  sg_descriptor_chain_with_residue_unit #(
    .MAX_DESCRIPTORS(TABLE_SLOTS),
    .MAX_CHUNK_BYTES(CHUNK_BYTES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [31:0] branch_link(input int unsigned slot);
    return shadow_base + 32'(16 * (slot + 1));
  endfunction

  // work out the results of one accepted request and advance the shadow
  task automatic predict_descriptors(input sgdc_req_t rq);
    int unsigned pieces, left, piece, walked, k;
    logic [31:0] at;
    longint unsigned cur64, lo64;
    logic hit;
    sgdc_res_t r;
    r = '0;
    r.last_result = 1'b1;
    case (rq.func)
      FUNC_CLEAR: begin
        shadow_count = 0;
        shadow_total = 0;
      end
      FUNC_APPEND: begin
        left = rq.segment_length;
        pieces = (left + CHUNK_BYTES - 1) / CHUNK_BYTES;
        if (pieces == 0) begin
          // zero length: only a last segment answers
          if (rq.last_segment) begin
            if (shadow_count == 0) begin
              r.status = ST_EMPTY;
            end else begin
              k = shadow_count - 1;
              r.desc_control = {16'h0, shadow_len[k]} | CTL_FORMAT | CTL_END | CTL_INTR;
              r.desc_data_addr = shadow_addr[k];
              r.desc_branch_addr = branch_link(k);
            end
            descriptors_due.push_back(r);
          end
        end else if (pieces > CHUNK_LIMIT || shadow_count + pieces > TABLE_SLOTS ||
                     shadow_total + left > TOTAL_MAX) begin
          r.status = ST_OVERFLOW;
          descriptors_due.push_back(r);
        end else begin
          at = rq.segment_addr;
          for (k = 0; k < pieces; k++) begin
            piece = (left > CHUNK_BYTES) ? CHUNK_BYTES : left;
            shadow_addr[shadow_count] = at;
            shadow_len[shadow_count] = 16'(piece);
            r.desc_control = 32'(piece) | CTL_FORMAT;
            if (k + 1 == pieces && rq.last_segment)
              r.desc_control = r.desc_control | CTL_END | CTL_INTR;
            r.desc_data_addr = at;
            r.desc_branch_addr = branch_link(shadow_count);
            r.last_result = (k + 1 == pieces);
            descriptors_due.push_back(r);
            shadow_count++;
            shadow_total += piece;
            at += 32'(piece);
            left -= piece;
          end
        end
      end
      FUNC_QUERY: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // first chunk holding the address wins, bounds taken without wrap
          walked = 0;
          hit = 1'b0;
          cur64 = rq.current_address;
          for (k = 0; k < shadow_count && !hit; k++) begin
            lo64 = shadow_addr[k];
            if (cur64 >= lo64 && cur64 <= lo64 + shadow_len[k]) begin
              walked += 32'(cur64 - lo64);
              hit = 1'b1;
            end else begin
              walked += shadow_len[k];
            end
          end
          r.residue = 23'(hit ? shadow_total - walked : shadow_total);
        end
        descriptors_due.push_back(r);
      end
      default: ;
    endcase
  endtask

  // request driver: bursts with random gaps, start held until taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_descriptors(req_i);
        requests_accepted++;
        if (burst_left > 0)
          burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!(start && busy)) begin
        raise_start = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (requests_pending.size() != 0 &&
                     !(requests_pending[0].drain &&
                       (descriptors_due.size() != 0 || busy))) begin
          req_i <= requests_pending[0].req;
          void'(requests_pending.pop_front());
          raise_start = 1'b1;
        end
        start <= raise_start;
      end
    end
  end

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected %h got %h", $time, what, want, got);
    end
  endtask

  // result monitor: every strobe is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (descriptors_due.size() == 0) begin
        mismatches++;
        $display("%0t ns: result expected none got %h", $time, res_o);
      end else begin
        compare_field("desc_control", descriptors_due[0].desc_control, res_o.desc_control);
        compare_field("desc_data_addr", descriptors_due[0].desc_data_addr,
                      res_o.desc_data_addr);
        compare_field("desc_branch_addr", descriptors_due[0].desc_branch_addr,
                      res_o.desc_branch_addr);
        compare_field("residue", 32'(descriptors_due[0].residue), 32'(res_o.residue));
        compare_field("status", 32'(descriptors_due[0].status), 32'(res_o.status));
        compare_field("last_result", 32'(descriptors_due[0].last_result),
                      32'(res_o.last_result));
        if (descriptors_due[0].status != ST_OK)
          flags_seen++;
        else if (descriptors_due[0].desc_control != '0)
          descriptors_seen++;
        else
          residues_seen++;
        void'(descriptors_due.pop_front());
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("%0t ns: run limit of %0d cycles reached", $time, RUN_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_request(input logic [1:0] func, input logic [31:0] addr,
                               input logic [21:0] len, input logic last,
                               input logic [31:0] cur, input bit drain);
    queued_request_t q;
    q.req.func = func;
    q.req.segment_addr = addr;
    q.req.segment_length = len;
    q.req.last_segment = last;
    q.req.current_address = cur;
    q.drain = drain;
    requests_pending.push_back(q);
  endtask

  // wait until all requests are taken and answered, then let the unit settle
  task automatic wait_chain_idle();
    while (requests_pending.size() != 0 || start || descriptors_due.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy)
      @(posedge clk_i);
  endtask

  task automatic write_table_base(input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_base = value;
  endtask

  function automatic logic [21:0] pick_segment_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return 22'($urandom_range(1, 600));
      4, 5:    return 22'($urandom_range(600, 140000));
      6:       return 22'($urandom_range(CHUNK_BYTES - 2, CHUNK_BYTES + 2));
      7:       return 22'($urandom_range(4194040, 4194303));
      default: return 22'($urandom);
    endcase
  endfunction

  // random chains: mostly clear, appends, queries aimed inside the segments
  task automatic queue_random_traffic(input int unsigned want);
    int unsigned made, k, nseg, j;
    logic [31:0] seg_a[$];
    logic [21:0] seg_l[$];
    logic [31:0] a, cur;
    logic [21:0] l;
    made = 0;
    while (made < want) begin
      seg_a.delete();
      seg_l.delete();
      if ($urandom_range(0, 3) != 0) begin
        queue_request(FUNC_CLEAR, $urandom, 22'($urandom), 1'($urandom), $urandom,
                      $urandom_range(0, 3) == 0);
        made++;
      end
      nseg = $urandom_range(1, 6);
      for (k = 0; k < nseg; k++) begin
        a = $urandom;
        l = pick_segment_length();
        queue_request(FUNC_APPEND, a, l,
                      (k + 1 == nseg) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 5) == 0),
                      $urandom, 1'b0);
        seg_a.push_back(a);
        seg_l.push_back(l);
        made++;
        if ($urandom_range(0, 2) == 0) begin
          queue_request(FUNC_QUERY, $urandom, 22'($urandom), 1'($urandom),
                        a + $urandom_range(0, l), 1'b0);
          made++;
        end
      end
      for (k = $urandom_range(1, 4); k > 0; k--) begin
        j = $urandom_range(0, seg_a.size() - 1);
        cur = ($urandom_range(0, 3) != 0) ? seg_a[j] + $urandom_range(0, seg_l[j]) : $urandom;
        queue_request(FUNC_QUERY, $urandom, 22'($urandom), 1'($urandom), cur, 1'b0);
        made++;
      end
      // noise: unused code or a request with all fields random
      if ($urandom_range(0, 4) == 0)
        queue_request(FUNC_UNUSED, $urandom, 22'($urandom), 1'($urandom), $urandom, 1'b0);
      if ($urandom_range(0, 4) == 0) begin
        queue_request(2'($urandom_range(0, 2)), $urandom, 22'($urandom), 1'($urandom),
                      $urandom, 1'b0);
        made++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_table_base(32'h1000_0000);
    // empty chain answers and ignored requests
    queue_request(FUNC_QUERY, '0, '0, 1'b0, 32'hFFFF_FFFF, 1'b0);
    queue_request(FUNC_APPEND, '0, '0, 1'b1, '0, 1'b0);
    queue_request(FUNC_APPEND, 32'hFFFF_FFFF, '0, 1'b0, '0, 1'b0);
    queue_request(FUNC_UNUSED, 32'hFFFF_FFFF, 22'h3F_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
    // segment whose chunk addresses wrap, then a one-byte last segment
    queue_request(FUNC_APPEND, 32'hFFFF_0000, 22'd200000, 1'b0, '0, 1'b0);
    queue_request(FUNC_APPEND, 32'h0000_1000, 22'd1, 1'b1, '0, 1'b0);
    queue_request(FUNC_QUERY, '0, '0, 1'b0, 32'hFFFF_0000, 1'b0);
    queue_request(FUNC_QUERY, '0, '0, 1'b0, 32'h0001_0000, 1'b0);
    queue_request(FUNC_QUERY, '0, '0, 1'b0, 32'h0000_1001, 1'b0);
    queue_request(FUNC_QUERY, '0, '0, 1'b0, 32'h8000_0000, 1'b0);
    // zero-length last segment re-marks the final descriptor
    queue_request(FUNC_APPEND, 32'h5555_5555, '0, 1'b1, '0, 1'b0);
    // 65 chunks never fit
    queue_request(FUNC_APPEND, 32'hAAAA_AAAA, 22'h3F_FFFF, 1'b1, '0, 1'b0);
    queue_request(FUNC_CLEAR, '0, '0, 1'b0, '0, 1'b0);
    // two 64-chunk segments fill the table exactly
    queue_request(FUNC_APPEND, 32'h8000_0000, 22'd4194048, 1'b0, '0, 1'b0);
    queue_request(FUNC_APPEND, 32'hFFFF_FFFF, 22'd4194048, 1'b1, '0, 1'b1);
    queue_request(FUNC_APPEND, '0, 22'd1, 1'b1, '0, 1'b0);
    queue_request(FUNC_APPEND, '0, '0, 1'b1, '0, 1'b0);
    queue_request(FUNC_QUERY, '0, '0, 1'b0, 32'h0000_0000, 1'b0);
    queue_request(FUNC_QUERY, '0, '0, 1'b0, 32'hFFFF_FFFF, 1'b0);
    queue_request(FUNC_CLEAR, '0, '0, 1'b0, '0, 1'b0);
    // chunk size boundary and a query at the end of a chunk
    queue_request(FUNC_APPEND, '0, 22'(CHUNK_BYTES), 1'b0, '0, 1'b0);
    queue_request(FUNC_APPEND, 32'h1234_5678, 22'(CHUNK_BYTES + 1), 1'b1, '0, 1'b0);
    queue_request(FUNC_QUERY, '0, '0, 1'b0, 32'h0000_FFFC, 1'b0);
    queue_request(FUNC_CLEAR, '0, '0, 1'b0, '0, 1'b1);
    queue_request(FUNC_QUERY, '0, '0, 1'b0, 32'h0000_0000, 1'b0);
    wait_chain_idle();

    // branch links wrap right away at the top base
    write_table_base(32'hFFFF_FFFF);
    queue_random_traffic(RANDOM_PER_PHASE);
    wait_chain_idle();
    write_table_base(32'h0000_0000);
    queue_random_traffic(RANDOM_PER_PHASE);
    wait_chain_idle();
    write_table_base($urandom);
    queue_random_traffic(RANDOM_PER_PHASE);
    wait_chain_idle();
    write_table_base($urandom);
    queue_random_traffic(RANDOM_PER_PHASE);
    wait_chain_idle();
    repeat (140) @(posedge clk_i);

    foreach (descriptors_due[i]) begin
      mismatches++;
      $display("%0t ns: result expected %h got none", $time, descriptors_due[i]);
    end
    $display("covered %0d requests over 5 table bases: %0d descriptors, %0d residue answers,",
             requests_accepted, descriptors_seen, residues_seen);
    $display("%0d overflow or empty-chain flags, %0d field mismatches", flags_seen, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
